FILE: src/mctc_pkg.sv
package mctc_pkg;

	localparam int SETS_DEF        = 128;
	localparam int WAYS_DEF        = 8;
	localparam int OFFSET_BITS_DEF = 5;
	localparam int ADDR_BITS_DEF   = 32;

	localparam int IN_ADDR_W = 32;

	localparam logic [1:0] REQ_CPU_RD   = 2'd0;
	localparam logic [1:0] REQ_CPU_WR   = 2'd1;
	localparam logic [1:0] REQ_SNOOP_RD = 2'd2;
	localparam logic [1:0] REQ_SNOOP_WR = 2'd3;

	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_E = 3'd1;
	localparam logic [2:0] ST_S = 3'd2;
	localparam logic [2:0] ST_M = 3'd3;
	localparam logic [2:0] ST_O = 3'd4;

	localparam logic [2:0] OUT_RD_HIT    = 3'd0;
	localparam logic [2:0] OUT_RD_MISS   = 3'd1;
	localparam logic [2:0] OUT_WR_HIT    = 3'd2;
	localparam logic [2:0] OUT_WR_MISS   = 3'd3;
	localparam logic [2:0] OUT_SNP_HIT   = 3'd4;
	localparam logic [2:0] OUT_SNP_MISS  = 3'd5;

	localparam logic [1:0] BUS_NONE  = 2'd0;
	localparam logic [1:0] BUS_PROBE = 2'd1;
	localparam logic [1:0] BUS_WTHRU = 2'd2;
	localparam logic [1:0] BUS_FETCH = 2'd3;

	localparam logic [2:0] AGE_MAX = 3'd7;

	typedef struct packed {
		logic [1:0] req_type;
		logic [IN_ADDR_W-1:0] address;
		logic from_memory;
	} req_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [2:0] way;
		logic [2:0] prior_state;
		logic [2:0] next_state;
		logic [1:0] bus_request;
		logic memory_write;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} stat_t;

endpackage

FILE: src/mctc_if.sv
interface mctc_req_if;
	logic valid;
	logic ready;
	mctc_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mctc_rsp_if;
	logic valid;
	logic ready;
	mctc_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/mctc_ctrl.sv
module mctc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  mctc_pkg::stat_t stat,
	output mctc_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;
	logic valid_q;
	logic take;
	logic out_free;

	// The result register is free when it is empty or its result leaves at this edge. A new
	// request may enter while the previous result still waits; the write-back then holds
	// until the register is free.
	assign out_free = !valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && !stat.clearing;
	assign take = in_valid && in_ready;
	assign cmd.capture = take;
	assign cmd.lookup = (state_q == S_LOOK);
	assign cmd.update = (state_q == S_UPD) && out_free;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) state_q <= S_LOOK;
				end
				S_LOOK: state_q <= S_UPD;
				S_UPD: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.update) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q)
		else $error("result overwritten");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |=> (state_q == S_UPD))
		else $error("bad sequence");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_LOOK))
		else $error("request lost");

endmodule

FILE: src/mctc_dp.sv
module mctc_dp #(
	parameter int SETS        = mctc_pkg::SETS_DEF,
	parameter int WAYS        = mctc_pkg::WAYS_DEF,
	parameter int OFFSET_BITS = mctc_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = mctc_pkg::ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  mctc_pkg::req_t req,
	input  mctc_pkg::cmd_t cmd,
	output mctc_pkg::stat_t stat,
	output mctc_pkg::rsp_t rsp
);

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int EFF_W  = (ADDR_BITS < mctc_pkg::IN_ADDR_W) ? ADDR_BITS : mctc_pkg::IN_ADDR_W;
	localparam int BLK_W  = EFF_W - OFFSET_BITS;
	localparam int TAG_W  = BLK_W;
	localparam int ROW_W  = WAYS * 3;
	localparam int CLR_W  = SET_W + 1;

	// One row per set: tags, states and ages of all ways.
	logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
	logic [ROW_W-1:0] st_mem [SETS];
	logic [ROW_W-1:0] age_mem [SETS];

	logic [WAYS-1:0][TAG_W-1:0] tag_rd_s1;
	logic [WAYS-1:0][2:0] st_rd_s1, age_rd_s1;
	logic [1:0] rt_q;
	logic fm_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [CLR_W-1:0] clr_q;

	logic [BLK_W-1:0] blk;
	logic [SET_W-1:0] set_c;
	logic [TAG_W-1:0] tag_c;
	always_comb begin
		blk = req.address[EFF_W-1:OFFSET_BITS];
		set_c = SET_W'(blk % SETS);
		tag_c = TAG_W'(blk / SETS);
	end

	assign stat.clearing = !clr_q[CLR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_q[CLR_W-1]) begin
			if (clr_q[SET_W-1:0] == SET_W'(SETS - 1)) clr_q <= CLR_W'(1) << SET_W;
			else clr_q <= clr_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rt_q <= req.req_type;
			fm_q <= req.from_memory;
			set_q <= set_c;
			tag_q <= tag_c;
		end
		if (cmd.lookup) begin
			tag_rd_s1 <= tag_mem[set_q];
			st_rd_s1 <= st_mem[set_q];
			age_rd_s1 <= age_mem[set_q];
		end
	end

	// Lookup, victim choice and new state from the registered row.
	logic hit;
	logic [WAY_W-1:0] hw, vw, w_sel;
	logic any_inv;
	logic [WAY_W-1:0] inv_w, old_w;
	logic [2:0] best_age, prior, nxt;
	logic [WAYS-1:0][2:0] st_new, age_new;
	logic fill;
	mctc_pkg::rsp_t r;

	always_comb begin
		hit = 1'b0; hw = '0; any_inv = 1'b0; inv_w = '0; old_w = '0; best_age = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (st_rd_s1[w] != mctc_pkg::ST_I && tag_rd_s1[w] == tag_q) begin
				hit = 1'b1; hw = WAY_W'(w);
			end
			if (st_rd_s1[w] == mctc_pkg::ST_I) begin
				any_inv = 1'b1; inv_w = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (w == 0 || age_rd_s1[w] > best_age) begin
				best_age = age_rd_s1[w]; old_w = WAY_W'(w);
			end
		end
		vw = any_inv ? inv_w : old_w;
		fill = !rt_q[1] && !hit;
		w_sel = fill ? vw : hw;
		prior = (hit || fill) ? st_rd_s1[w_sel] : mctc_pkg::ST_I;
		r = '0;
		nxt = mctc_pkg::ST_I;
		case (rt_q)
			mctc_pkg::REQ_CPU_RD: begin
				if (hit) begin
					r.outcome = mctc_pkg::OUT_RD_HIT; nxt = prior;
					r.bus_request = mctc_pkg::BUS_PROBE;
				end else begin
					r.outcome = mctc_pkg::OUT_RD_MISS;
					nxt = fm_q ? mctc_pkg::ST_E : mctc_pkg::ST_S;
					r.bus_request = mctc_pkg::BUS_FETCH;
				end
			end
			mctc_pkg::REQ_CPU_WR: begin
				nxt = mctc_pkg::ST_M;
				if (hit) begin
					r.outcome = mctc_pkg::OUT_WR_HIT;
					r.bus_request = mctc_pkg::BUS_WTHRU;
				end else begin
					r.outcome = mctc_pkg::OUT_WR_MISS;
					r.bus_request = mctc_pkg::BUS_FETCH;
					r.memory_write = fm_q;
				end
			end
			default: begin
				if (!hit) r.outcome = mctc_pkg::OUT_SNP_MISS;
				else begin
					r.outcome = mctc_pkg::OUT_SNP_HIT;
					if (rt_q == mctc_pkg::REQ_SNOOP_WR) nxt = mctc_pkg::ST_I;
					else if (prior == mctc_pkg::ST_E) nxt = mctc_pkg::ST_S;
					else if (prior == mctc_pkg::ST_M) nxt = mctc_pkg::ST_O;
					else nxt = prior;
				end
			end
		endcase
		r.way = (hit || fill) ? 3'(w_sel) : 3'd0;
		r.prior_state = prior;
		r.next_state = nxt;
		st_new = st_rd_s1;
		age_new = age_rd_s1;
		if (hit || fill) st_new[w_sel] = nxt;
		if (fill) begin
			for (int w = 0; w < WAYS; w++) begin
				if (WAY_W'(w) == vw) age_new[w] = '0;
				else if (st_rd_s1[w] != mctc_pkg::ST_I && age_rd_s1[w] < mctc_pkg::AGE_MAX)
					age_new[w] = age_rd_s1[w] + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[CLR_W-1]) begin
			st_mem[clr_q[SET_W-1:0]] <= '0;
			age_mem[clr_q[SET_W-1:0]] <= '0;
		end else if (cmd.update) begin
			st_mem[set_q] <= st_new;
			age_mem[set_q] <= age_new;
		end
		if (cmd.update && fill) tag_mem[set_q][vw] <= tag_q;
		if (cmd.update) rsp <= r;
	end

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !cmd.capture)
		else $error("request during clear");
	a_fill_cpu: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && fill) |-> (r.bus_request == mctc_pkg::BUS_FETCH))
		else $error("fill without fetch");
	a_snoop_no_age: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && rt_q[1]) |-> (age_new == age_rd_s1))
		else $error("snoop changed ages");

endmodule

FILE: src/moesi_cache_tag_controller_core.sv
// MOESI tag and state array for an N-way set-associative cache. Each request
// (CPU read, CPU write, snoop read, snoop write) returns one result giving
// hit or miss, the way involved, the line state before and after, the bus
// request raised and whether memory is written. From acceptance the request is
// captured, then the set row is read from the tag and state memory, then the
// new state and ages are written back and the result is registered. One request
// is in flight at a time: the next is not accepted until the previous one has
// been written back, as the set memory is read and then written per request.
// The next request may be accepted while the previous result still waits; its
// write-back is held until that result has been taken. After reset, a clearing
// pass over all SETS rows sets every line INVALID with age zero; no request is
// accepted until it completes.
module moesi_cache_tag_controller_core #(
	parameter int SETS        = mctc_pkg::SETS_DEF,
	parameter int WAYS        = mctc_pkg::WAYS_DEF,
	parameter int OFFSET_BITS = mctc_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS   = mctc_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mctc_req_if.sink req,
	mctc_rsp_if.source rsp
);

	mctc_pkg::cmd_t cmd;
	mctc_pkg::stat_t stat;

	// Sequencing of each request through lookup and write-back.
	mctc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.stat(stat), .cmd(cmd)
	);

	// Set memories, hit detection, victim choice and state update.
	mctc_dp #(
		.SETS(SETS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS), .ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req(req.payload), .cmd(cmd), .stat(stat), .rsp(rsp.payload)
	);

endmodule
